[rtl/core/nca_pkg.sv]
// nca_pkg: shared types and constants for the nearest centroid assignment block
// used by nca_cell, nearest_centroid_assign and nca_checker; no dependencies
package nca_pkg;

	localparam int MAX_CENTROIDS_DEF = 32;
	localparam int COORD_BITS_DEF    = 17;

	// apb register map
	localparam int   APB_DATA_W = 32;
	localparam int   PADDR_W    = 3;
	localparam logic REG_COUNT  = 1'b0;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_POINT = 1'b1
	} kind_t;

	// control travelling with each beat along the chain
	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctl_t;

endpackage

[rtl/core/nca_cell.sv]
// nca_cell: one centroid slot of the systolic chain, two register stages
// stage 1 squares the coordinate differences, stage 2 keeps the running minimum
// depends on nca_pkg
module nca_cell
	import nca_pkg::*;
#(
	parameter int IDX           = 0,
	parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic [$clog2(MAX_CENTROIDS+1)-1:0]   count,
	input  ctl_t                                 ctl_in,
	input  logic [$clog2(MAX_CENTROIDS)-1:0]     slot_in,
	input  logic [COORD_BITS-1:0]                x_in,
	input  logic [COORD_BITS-1:0]                y_in,
	input  logic [2*COORD_BITS:0]                best_in,
	input  logic [$clog2(MAX_CENTROIDS)-1:0]     bidx_in,
	output ctl_t                                 ctl_out,
	output logic [$clog2(MAX_CENTROIDS)-1:0]     slot_out,
	output logic [COORD_BITS-1:0]                x_out,
	output logic [COORD_BITS-1:0]                y_out,
	output logic [2*COORD_BITS:0]                best_out,
	output logic [$clog2(MAX_CENTROIDS)-1:0]     bidx_out
);

	localparam int  IDX_W     = $clog2(MAX_CENTROIDS);
	localparam int  CNT_W     = $clog2(MAX_CENTROIDS + 1);
	localparam int  SQ_W      = 2 * COORD_BITS;
	localparam int  DIST_W    = 2 * COORD_BITS + 1;
	localparam bit  ALWAYS_ON = (IDX == 0);

	logic [COORD_BITS-1:0] cx_q, cy_q;
	logic [COORD_BITS-1:0] dx, dy;
	logic [SQ_W-1:0]       dx_w, dy_w;

	ctl_t                  ctl_s1;
	logic [IDX_W-1:0]      slot_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [DIST_W-1:0]     best_s1;
	logic [IDX_W-1:0]      bidx_s1;
	logic [SQ_W-1:0]       sqx_s1, sqy_s1;

	logic [DIST_W-1:0]     dist_sum;
	logic                  active;
	logic                  take;

	ctl_t                  ctl_s2;
	logic [IDX_W-1:0]      slot_s2;
	logic [COORD_BITS-1:0] x_s2, y_s2;
	logic [DIST_W-1:0]     best_s2;
	logic [IDX_W-1:0]      bidx_s2;

	assign dx   = (x_in >= cx_q) ? (x_in - cx_q) : (cx_q - x_in);
	assign dy   = (y_in >= cy_q) ? (y_in - cy_q) : (cy_q - y_in);
	assign dx_w = {{COORD_BITS{1'b0}}, dx};
	assign dy_w = {{COORD_BITS{1'b0}}, dy};

	// centroid held by this slot, written as a load beat enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (en && ctl_in.valid && ctl_in.kind == KIND_LOAD
				&& slot_in == IDX_W'(IDX)) begin
			cx_q <= x_in;
			cy_q <= y_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= slot_in;
			x_s1    <= x_in;
			y_s1    <= y_in;
			best_s1 <= best_in;
			bidx_s1 <= bidx_in;
			sqx_s1  <= dx_w * dx_w;
			sqy_s1  <= dy_w * dy_w;
		end
	end

	assign dist_sum = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	assign active   = ALWAYS_ON || (CNT_W'(IDX) < count);
	assign take     = active && (dist_sum < best_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s2 <= slot_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			best_s2 <= take ? dist_sum : best_s1;
			bidx_s2 <= take ? IDX_W'(IDX) : bidx_s1;
		end
	end

	assign ctl_out  = ctl_s2;
	assign slot_out = slot_s2;
	assign x_out    = x_s2;
	assign y_out    = y_s2;
	assign best_out = best_s2;
	assign bidx_out = bidx_s2;

endmodule

[rtl/core/nearest_centroid_assign.sv]
// nearest_centroid_assign: top level, apb register, chain of nca_cell and output register
// depends on nca_pkg and nca_cell
//
// Usage:
//   item channel (item_valid/item_stall): kind selects a centroid load (slot_index,
//   x_coord, y_coord) or a point to classify (x_coord, y_coord).
//   result channel (result_valid/result_stall): one beat per point, carrying
//   nearest_index and nearest_dist_sq; loads give no result beat.
//   Every beat walks a chain of MAX_CENTROIDS cells, one per centroid, each with two
//   register stages, then an output register.
//   Throughput is one item per cycle while item_stall is low; loads and points keep their order, so a load
//   affects exactly the points that follow it.
//   centroids_in_use sits at apb address 0 and resets to MAX_CENTROIDS; write it
//   only while no beats are in flight.
//   Reset clears the chain, zeroes every centroid and drops result_valid.
//   While a result beat is stalled the whole chain holds and item_stall is high.
module nearest_centroid_assign
	import nca_pkg::*;
#(
	parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [PADDR_W-1:0]                 paddr,
	input  logic [APB_DATA_W-1:0]              pwdata,
	output logic [APB_DATA_W-1:0]              prdata,
	output logic                               pready,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               kind,
	input  logic [$clog2(MAX_CENTROIDS)-1:0]   slot_index,
	input  logic [COORD_BITS-1:0]              x_coord,
	input  logic [COORD_BITS-1:0]              y_coord,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [$clog2(MAX_CENTROIDS)-1:0]   nearest_index,
	output logic [2*COORD_BITS:0]              nearest_dist_sq
);

	localparam int IDX_W  = $clog2(MAX_CENTROIDS);
	localparam int CNT_W  = $clog2(MAX_CENTROIDS + 1);
	localparam int DIST_W = 2 * COORD_BITS + 1;

	logic [CNT_W-1:0]      count_q;
	logic                  en;

	ctl_t                  ch_ctl  [MAX_CENTROIDS+1];
	logic [IDX_W-1:0]      ch_slot [MAX_CENTROIDS+1];
	logic [COORD_BITS-1:0] ch_x    [MAX_CENTROIDS+1];
	logic [COORD_BITS-1:0] ch_y    [MAX_CENTROIDS+1];
	logic [DIST_W-1:0]     ch_best [MAX_CENTROIDS+1];
	logic [IDX_W-1:0]      ch_bidx [MAX_CENTROIDS+1];

	logic                  result_valid_q;
	logic [IDX_W-1:0]      nearest_index_q;
	logic [DIST_W-1:0]     nearest_dist_sq_q;

	// apb register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(MAX_CENTROIDS);
		end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_COUNT) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1] == REG_COUNT) ? APB_DATA_W'(count_q) : '0;
	assign pready = 1'b1;

	assign en         = !result_valid_q || !result_stall;
	assign item_stall = !en;

	// head of the chain
	assign ch_ctl[0].valid = item_valid;
	assign ch_ctl[0].kind  = kind_t'(kind);
	assign ch_slot[0]      = slot_index;
	assign ch_x[0]         = x_coord;
	assign ch_y[0]         = y_coord;
	assign ch_best[0]      = '1;
	assign ch_bidx[0]      = '0;

	for (genvar i = 0; i < MAX_CENTROIDS; i++) begin : g_cell
		nca_cell #(
			.IDX          (i),
			.MAX_CENTROIDS(MAX_CENTROIDS),
			.COORD_BITS   (COORD_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.count   (count_q),
			.ctl_in  (ch_ctl[i]),
			.slot_in (ch_slot[i]),
			.x_in    (ch_x[i]),
			.y_in    (ch_y[i]),
			.best_in (ch_best[i]),
			.bidx_in (ch_bidx[i]),
			.ctl_out (ch_ctl[i+1]),
			.slot_out(ch_slot[i+1]),
			.x_out   (ch_x[i+1]),
			.y_out   (ch_y[i+1]),
			.best_out(ch_best[i+1]),
			.bidx_out(ch_bidx[i+1])
		);
	end

	// output register, only points leave as result beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= ch_ctl[MAX_CENTROIDS].valid
				&& ch_ctl[MAX_CENTROIDS].kind == KIND_POINT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nearest_index_q   <= ch_bidx[MAX_CENTROIDS];
			nearest_dist_sq_q <= ch_best[MAX_CENTROIDS];
		end
	end

	assign result_valid    = result_valid_q;
	assign nearest_index   = nearest_index_q;
	assign nearest_dist_sq = nearest_dist_sq_q;

endmodule

[rtl/core/nca_checker.sv]
// nca_checker: port-level assertions for nearest_centroid_assign, bound to the top level
// depends on nca_pkg and nearest_centroid_assign
module nca_checker
	import nca_pkg::*;
#(
	parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic [PADDR_W-1:0]                 paddr,
	input logic [APB_DATA_W-1:0]              prdata,
	input logic                               pready,
	input logic                               item_stall,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic [$clog2(MAX_CENTROIDS)-1:0]   nearest_index,
	input logic [2*COORD_BITS:0]              nearest_dist_sq
);

	localparam int CNT_W = $clog2(MAX_CENTROIDS + 1);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(nearest_index) && $stable(nearest_dist_sq))
		else $error("stalled result beat changed");

	// the input side backs up exactly when the output is blocked
	a_stall_tie: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("item_stall does not follow the output register");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (int'(nearest_index) < MAX_CENTROIDS))
		else $error("nearest_index beyond the centroid store");

	a_apb_read: assert property (@(posedge clk) disable iff (!arst_n)
		pready && (prdata[APB_DATA_W-1:CNT_W] == '0)
		&& ((paddr[PADDR_W-1] == REG_COUNT) || (prdata == '0)))
		else $error("apb read data outside the register map");

endmodule

bind nearest_centroid_assign nca_checker #(
	.MAX_CENTROIDS(MAX_CENTROIDS),
	.COORD_BITS   (COORD_BITS)
) u_nca_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.paddr          (paddr),
	.prdata         (prdata),
	.pready         (pready),
	.item_stall     (item_stall),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.nearest_index  (nearest_index),
	.nearest_dist_sq(nearest_dist_sq)
);

[tb/tb.sv]
// tb: self-checking bench for nearest_centroid_assign, loads and points streamed
// through the item channel, results checked beat by beat against a local predictor
// depends on nca_pkg and the nearest_centroid_assign rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nca_pkg::*;

	localparam int N_SLOTS        = MAX_CENTROIDS_DEF;
	localparam int COORD_W        = COORD_BITS_DEF;
	localparam int IDX_W          = $clog2(N_SLOTS);
	localparam int DIST_W         = 2*COORD_W+1;
	localparam int LATENCY        = 2*N_SLOTS+1;
	localparam int SETTLE         = LATENCY+16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 180;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;
	localparam logic [PADDR_W-1:0] ADDR_IN_USE = PADDR_W'(4*REG_COUNT);
	// first address past the register map
	localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(4);

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dist_sq;
	} nearest_t;

	class nearest_tracker;
		logic [COORD_W-1:0] cent_x [N_SLOTS];
		logic [COORD_W-1:0] cent_y [N_SLOTS];
		logic [5:0]         in_use;
		nearest_t           due_nearest [$];
		int                 mismatches;

		function new();
			foreach (cent_x[i]) begin
				cent_x[i] = '0;
				cent_y[i] = '0;
			end
			in_use     = 6'd32;
			mismatches = 0;
		endfunction

		function void set_in_use(logic [APB_DATA_W-1:0] v);
			in_use = v[5:0];
		endfunction

		function void flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void note_item(kind_t k, logic [IDX_W-1:0] s,
				logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
			int                 n;
			logic [COORD_W-1:0] dx;
			logic [COORD_W-1:0] dy;
			logic [DIST_W-1:0]  d;
			nearest_t           r;
			if (k == KIND_LOAD) begin
				cent_x[s] = x;
				cent_y[s] = y;
				return;
			end
			n = (in_use == 0) ? 1 : ((in_use > N_SLOTS) ? N_SLOTS : int'(in_use));
			r = '0;
			for (int j = 0; j < n; j++) begin
				dx = (x >= cent_x[j]) ? x - cent_x[j] : cent_x[j] - x;
				dy = (y >= cent_y[j]) ? y - cent_y[j] : cent_y[j] - y;
				d  = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
				if (j == 0 || d < r.dist_sq) begin
					r.dist_sq = d;
					r.idx     = IDX_W'(j);
				end
			end
			due_nearest.push_back(r);
		endfunction

		function void check_nearest(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] dist_sq);
			nearest_t r;
			if (due_nearest.size() == 0) begin
				flag_mismatch($sformatf("tb: result beat with nothing due: index %0d dist %0d",
					idx, dist_sq));
				return;
			end
			r = due_nearest.pop_front();
			if (idx !== r.idx || dist_sq !== r.dist_sq)
				flag_mismatch($sformatf(
					"tb: mismatch: expected index %0d dist %0d, got index %0d dist %0d",
					r.idx, r.dist_sq, idx, dist_sq));
		endfunction

		function int pending();
			return due_nearest.size();
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [PADDR_W-1:0]    paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	logic                  kind         = KIND_LOAD;
	logic [IDX_W-1:0]      slot_index   = '0;
	logic [COORD_W-1:0]    x_coord      = '0;
	logic [COORD_W-1:0]    y_coord      = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [IDX_W-1:0]      nearest_index;
	logic [DIST_W-1:0]     nearest_dist_sq;

	bit             calm = 1'b0;
	int             quiet_cycles = 0;
	nearest_tracker board = new();

	nearest_centroid_assign dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.kind            (kind),
		.slot_index      (slot_index),
		.x_coord         (x_coord),
		.y_coord         (y_coord),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.nearest_index   (nearest_index),
		.nearest_dist_sq (nearest_dist_sq)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_nearest(nearest_index, nearest_dist_sq);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && !calm && $urandom_range(0, 11) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(kind_t k, logic [IDX_W-1:0] s,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		if (!calm && $urandom_range(0, 9) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		slot_index <= s;
		x_coord    <= x;
		y_coord    <= y;
		do @(posedge clk); while (item_stall);
		board.note_item(k, s, x, y);
	endtask

	task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr,
			logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr && addr == ADDR_IN_USE)
			board.set_in_use(data);
		if (!wr && prdata !== data)
			board.flag_mismatch($sformatf("tb: register read: expected %0d, got %0d",
				data, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return COORD_W'($urandom_range(0, 15));
			1: return COORD_MAX - COORD_W'($urandom_range(0, 15));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic run_phase(int items);
		kind_t k;
		for (int i = 0; i < items; i++) begin
			k = ($urandom_range(0, 9) < 3) ? KIND_LOAD : KIND_POINT;
			send_item(k, IDX_W'($urandom_range(0, N_SLOTS-1)), pick_coord(), pick_coord());
		end
		item_valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic directed_items();
		send_item(KIND_POINT, 0, 0, 0);
		send_item(KIND_POINT, 31, COORD_MAX, COORD_MAX);
		send_item(KIND_LOAD, 31, COORD_MAX, COORD_MAX);
		send_item(KIND_POINT, 0, COORD_MAX, COORD_MAX);
		send_item(KIND_LOAD, 0, COORD_MAX, 0);
		send_item(KIND_POINT, 17, 0, 0);
		send_item(KIND_LOAD, 5, 100, 100);
		send_item(KIND_LOAD, 6, 100, 100);
		send_item(KIND_POINT, 0, 100, 100);
		send_item(KIND_LOAD, 9, 110, 90);
		send_item(KIND_LOAD, 10, 90, 110);
		send_item(KIND_POINT, 0, 105, 95);
		send_item(KIND_POINT, 0, 120, 80);
		send_item(KIND_POINT, 0, 80, 120);
		send_item(KIND_POINT, 21, 17'h15555, 17'h0aaaa);
		send_item(KIND_POINT, 10, 17'h0aaaa, 17'h15555);
		send_item(KIND_LOAD, 1, 17'h15555, 17'h0aaaa);
		send_item(KIND_POINT, 0, COORD_MAX, 0);
	endtask

	initial begin
		int                    settings [7] = '{1, 0, 63, 33, 17, -1, 32};
		logic [APB_DATA_W-1:0] data;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, ADDR_IN_USE, APB_DATA_W'(32));
		directed_items();
		run_phase(PHASE_ITEMS);
		foreach (settings[i]) begin
			drain();
			data      = $urandom();
			data[5:0] = (settings[i] < 0) ? 6'($urandom_range(2, 31)) : 6'(settings[i]);
			apb_access(1'b1, ADDR_IN_USE, data);
			apb_access(1'b0, ADDR_IN_USE, APB_DATA_W'(data[5:0]));
			if (i == 2) begin
				apb_access(1'b1, ADDR_SPARE, APB_DATA_W'($urandom_range(0, 63)));
				apb_access(1'b0, ADDR_IN_USE, APB_DATA_W'(data[5:0]));
			end
			if (i == $size(settings) - 1)
				calm = 1'b1;
			run_phase(PHASE_ITEMS);
		end
		drain();
		if (board.mismatches == 0 && board.pending() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
